>>> src/hse_pkg.sv
// ----------------------------------------------------------------------------
// HMAC-SHA-256 engine package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
package hse_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IKEY_LOAD,
        ST_ABSORB,
        ST_MSG_RUN,
        ST_PAD,
        ST_PAD_RUN,
        ST_OKEY_LOAD,
        ST_OKEY_RUN,
        ST_OMSG_LOAD,
        ST_OMSG_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRC_KEY_IN,
        SRC_KEY_OUT,
        SRC_BUF,
        SRC_INNER
    } blk_src_t;

    typedef struct packed {
        logic     init_chain;
        logic     clear_count;
        logic     absorb;
        logic     pad_step;
        logic     load_block;
        blk_src_t src;
        logic     round_step;
        logic     fold;
        logic     save_inner;
        logic     capture;
    } dp_cmd_t;

    typedef struct packed {
        logic       round_last;
        logic       buf_full;
        logic [6:0] fill;
    } dp_stat_t;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS = 7'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> src/hmac_sha256_engine_unit.sv
// ----------------------------------------------------------------------------
// HMAC-SHA-256 engine top level
// Byte stream in, HMAC-SHA-256 digest out, key in eight write registers.
// ----------------------------------------------------------------------------
// Usage: load key_word_0..7 through the write port while idle. Each slave
// transaction carries one byte (tdata) with tuser = byte_valid and
// tlast = end_of_message. The first item of a message starts the inner key
// block. Message bytes are taken one per cycle while a block fills; the
// 64th byte of a block starts a 64-round compression, during which tready
// is low. At end of message the padding takes one block, or two when the
// length needs a second block, then the outer hash runs the outer key
// block and the inner digest, and the digest passes to the output
// register. The digest waits in an output register until the receiver
// takes it while the next message streams in; only a second finished
// digest waits for that register to empty. Reset returns the block to
// idle with a cleared key. The single SHA-256 round unit runs all these
// blocks one after another.
// ----------------------------------------------------------------------------
module hmac_sha256_engine_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // data_byte
    input  logic          s_axis_tuser,   // byte_valid
    input  logic          s_axis_tlast,   // end_of_message
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [255:0]  m_axis_tdata,   // digest_0, digest_1, digest_2, digest_3
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);
    import hse_pkg::*;

    logic [63:0]  key_reg [8];
    logic [511:0] key_bits;
    logic [255:0] digest;
    dp_cmd_t      cmd;
    dp_stat_t     stat;
    logic         in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < 8; i++)
                key_reg[i] <= '0;
        else if (cfg_we)
            key_reg[cfg_index] <= cfg_data;
    end

    always_comb
        for (int i = 0; i < 8; i++)
            key_bits[511 - 64*i -: 64] = key_reg[i];

    assign in_fire = s_axis_tvalid && s_axis_tready;

    hse_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .byte_valid     (s_axis_tuser),
        .end_of_message (s_axis_tlast),
        .out_taken      (m_axis_tready),
        .stat           (stat),
        .cmd            (cmd),
        .in_ready       (s_axis_tready),
        .out_valid      (m_axis_tvalid)
    );

    hse_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_axis_tdata),
        .key_bits  (key_bits),
        .stat      (stat),
        .digest    (digest)
    );

    always_comb
        for (int i = 0; i < 4; i++)
            m_axis_tdata[64*i +: 64] = digest[255 - 64*i -: 64];

endmodule

>>> src/hse_ctrl.sv
// ----------------------------------------------------------------------------
// HMAC-SHA-256 controller
// Sequences key blocks, message absorption, padding and the outer hash.
// ----------------------------------------------------------------------------
module hse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              byte_valid,
    input  logic              end_of_message,
    input  logic              out_taken,
    input  hse_pkg::dp_stat_t stat,
    output hse_pkg::dp_cmd_t  cmd,
    output logic              in_ready,
    output logic              out_valid
);
    import hse_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   pad_done_reg, pad_done_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            pad_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            pad_done_reg  <= pad_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        pad_done_next  = pad_done_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_taken)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (byte_valid || end_of_message))
                begin
                    state_next = ST_IKEY_LOAD;
                    last_next  = end_of_message;
                end
            end
            ST_IKEY_LOAD: state_next = ST_MSG_RUN;
            ST_ABSORB:
            begin
                if (in_fire)
                begin
                    last_next = end_of_message;
                    if (byte_valid && stat.buf_full)
                        state_next = ST_MSG_RUN;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_MSG_RUN:
            begin
                if (stat.round_last)
                    state_next = last_reg ? ST_PAD : ST_ABSORB;
            end
            ST_PAD:
            begin
                pad_done_next = 1'b0;
                state_next    = ST_PAD_RUN;
            end
            ST_PAD_RUN:
            begin
                if (stat.round_last)
                begin
                    if (stat.fill == 7'd0 && !pad_done_reg)
                    begin
                        pad_done_next = 1'b1;
                        state_next    = ST_PAD_RUN;
                    end
                    else
                        state_next = ST_OKEY_LOAD;
                end
            end
            ST_OKEY_LOAD: state_next = ST_OKEY_RUN;
            ST_OKEY_RUN:  if (stat.round_last) state_next = ST_OMSG_LOAD;
            ST_OMSG_LOAD: state_next = ST_OMSG_RUN;
            ST_OMSG_RUN:  if (stat.round_last) state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_taken)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.src   = SRC_BUF;
        in_ready  = 1'b0;
        out_valid = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && (byte_valid || end_of_message))
                begin
                    cmd.init_chain  = 1'b1;
                    cmd.clear_count = 1'b1;
                    cmd.absorb      = byte_valid;
                end
            end
            ST_IKEY_LOAD:
            begin
                cmd.load_block = 1'b1;
                cmd.src        = SRC_KEY_IN;
            end
            ST_ABSORB:
            begin
                in_ready   = 1'b1;
                cmd.absorb = in_fire && byte_valid;
                if (in_fire && byte_valid && stat.buf_full)
                begin
                    cmd.load_block = 1'b1;
                    cmd.src        = SRC_BUF;
                end
            end
            ST_MSG_RUN:
            begin
                cmd.round_step = 1'b1;
                cmd.fold       = stat.round_last;
            end
            ST_PAD:
            begin
                cmd.pad_step   = 1'b1;
                cmd.load_block = 1'b1;
                cmd.src        = SRC_BUF;
            end
            ST_PAD_RUN:
            begin
                cmd.round_step = 1'b1;
                cmd.fold       = stat.round_last;
                if (stat.round_last && stat.fill == 7'd0 && !pad_done_reg)
                begin
                    cmd.pad_step   = 1'b1;
                    cmd.load_block = 1'b1;
                    cmd.src        = SRC_BUF;
                end
                cmd.save_inner = stat.round_last &&
                                 !(stat.fill == 7'd0 && !pad_done_reg);
            end
            ST_OKEY_LOAD:
            begin
                cmd.init_chain = 1'b1;
                cmd.load_block = 1'b1;
                cmd.src        = SRC_KEY_OUT;
            end
            ST_OKEY_RUN:
            begin
                cmd.round_step = 1'b1;
                cmd.fold       = stat.round_last;
            end
            ST_OMSG_LOAD:
            begin
                cmd.load_block = 1'b1;
                cmd.src        = SRC_INNER;
            end
            ST_OMSG_RUN:
            begin
                cmd.round_step = 1'b1;
                cmd.fold       = stat.round_last;
            end
            ST_DONE: cmd.capture = !out_valid_reg || out_taken;
            default: ;
        endcase
    end

endmodule

>>> src/hse_datapath.sv
// ----------------------------------------------------------------------------
// HMAC-SHA-256 datapath
// Byte buffer, message schedule, one SHA-256 round per cycle and chaining.
// ----------------------------------------------------------------------------
module hse_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  hse_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        data_byte,
    input  logic [511:0]      key_bits,
    output hse_pkg::dp_stat_t stat,
    output logic [255:0]      digest
);
    import hse_pkg::*;

    logic [7:0]   buf_reg [64];
    logic [6:0]   fill_reg;
    logic [60:0]  total_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   rnd_reg;
    logic [255:0] inner_reg;
    logic [255:0] digest_reg;

    logic [511:0] blk;
    logic [511:0] pad_blk;
    logic [63:0]  bit_len;
    logic [31:0]  wi, s0, s1, t1, t2, ws0, ws1, wnew;
    logic [31:0]  h_sum [8];
    logic         pad_second;

    assign stat.round_last = (rnd_reg == 6'd63);
    assign stat.buf_full   = (fill_reg == 7'd63);
    assign stat.fill       = fill_reg;

    assign bit_len    = {total_reg, 3'b000};
    // The second padding block carries only zeros and the length.
    assign pad_second = cmd.round_step;

    always_comb
    begin
        pad_blk = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (7'(i) < fill_reg)
                pad_blk[511 - 8*i -: 8] = buf_reg[i];
            else if (7'(i) == fill_reg && !pad_second)
                pad_blk[511 - 8*i -: 8] = PAD_BYTE;
        end
        if (fill_reg == 7'd64)
            pad_blk = '0;
        if (fill_reg < LEN_POS || pad_second)
            pad_blk[63:0] = bit_len;
    end

    always_comb
    begin
        blk = '0;
        unique case (cmd.src)
            SRC_KEY_IN:  for (int i = 0; i < 64; i++)
                             blk[511 - 8*i -: 8] = key_bits[511 - 8*i -: 8] ^ IPAD;
            SRC_KEY_OUT: for (int i = 0; i < 64; i++)
                             blk[511 - 8*i -: 8] = key_bits[511 - 8*i -: 8] ^ OPAD;
            SRC_BUF:
            begin
                if (cmd.pad_step)
                    blk = pad_blk;
                else
                begin
                    for (int i = 0; i < 63; i++)
                        blk[511 - 8*i -: 8] = buf_reg[i];
                    blk[7:0] = data_byte;
                end
            end
            SRC_INNER:   blk = {inner_reg, 8'h80, 184'd0, 64'd768};
            default:     blk = '0;
        endcase
    end

    assign ws0  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign ws1  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + ws0 + w_reg[9] + ws1;
    assign wi   = w_reg[0];
    assign s1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign t1   = v_reg[7] + s1 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                  + K_TAB[rnd_reg] + wi;
    assign s0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign t2   = s0 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        h_sum[0] = h_reg[0] + t1 + t2;
        h_sum[1] = h_reg[1] + v_reg[0];
        h_sum[2] = h_reg[2] + v_reg[1];
        h_sum[3] = h_reg[3] + v_reg[2];
        h_sum[4] = h_reg[4] + v_reg[3] + t1;
        h_sum[5] = h_reg[5] + v_reg[4];
        h_sum[6] = h_reg[6] + v_reg[5];
        h_sum[7] = h_reg[7] + v_reg[6];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
            buf_reg[fill_reg[5:0]] <= data_byte;
        if (cmd.load_block)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= cmd.init_chain ? H_INIT[i] : (cmd.fold ? h_sum[i] : h_reg[i]);
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.save_inner)
            for (int i = 0; i < 8; i++)
                inner_reg[255 - 32*i -: 32] <= h_sum[i];
        if (cmd.capture)
            for (int i = 0; i < 8; i++)
                digest_reg[255 - 32*i -: 32] <= h_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            rnd_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= H_INIT[i];
        end
        else
        begin
            if (cmd.clear_count)
            begin
                fill_reg  <= 7'(cmd.absorb);
                total_reg <= 61'd64 + 61'(cmd.absorb);
            end
            else if (cmd.absorb)
            begin
                fill_reg  <= stat.buf_full ? 7'd0 : fill_reg + 7'd1;
                total_reg <= total_reg + 61'd1;
            end
            else if (cmd.pad_step && cmd.round_step)
                fill_reg <= 7'd64;
            else if (cmd.pad_step)
                fill_reg <= (fill_reg >= LEN_POS) ? 7'd0 : 7'd64;
            if (cmd.round_step)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.init_chain)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= H_INIT[i];
            else if (cmd.fold)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_sum[i];
        end
    end

    assign digest = digest_reg;

endmodule

>>> src/hse_checker.sv
// ----------------------------------------------------------------------------
// HMAC-SHA-256 port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module hse_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata
);
    a_stall_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after end of message");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("digest while input open");
endmodule

bind hmac_sha256_engine_unit hse_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
